// ----- rtl/tbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Types and constants shared by the tank batch sequencer and its channels.
// ----------------------------------------------------------------------------
package tbs_pkg;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_FILL        = 3'd1,
      PH_STIR        = 3'd2,
      PH_DRAIN       = 3'd3,
      PH_FILL_PAUSE  = 3'd4,
      PH_STIR_PAUSE  = 3'd5,
      PH_DRAIN_PAUSE = 3'd6,
      PH_EMERGENCY   = 3'd7
   } phase_type;

   localparam int CountWidth = 8;
   localparam int DriveWidth = 7;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [DriveWidth-1:0] drive_type;

   // valve and heater patterns
   localparam drive_type DriveIdle      = 7'h10;
   localparam drive_type DriveFill      = 7'h13;
   localparam drive_type DriveStir      = 7'h08;
   localparam drive_type DriveDrain     = 7'h14;
   localparam drive_type DriveEmergency = 7'h70;

   function automatic drive_type drive_of(input phase_type ph);
      drive_type d;
      case (ph)
         PH_FILL:      d = DriveFill;
         PH_STIR:      d = DriveStir;
         PH_DRAIN:     d = DriveDrain;
         PH_EMERGENCY: d = DriveEmergency;
         default:      d = DriveIdle;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/tbs_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_req_if
// Tick channel: sampled button events and tank level pins.
// ----------------------------------------------------------------------------
interface tbs_req_if;
   logic valid;
   logic ready;
   logic start_press;
   logic emergency_press;
   logic count_up_press;
   logic count_clear_press;
   logic level_high_pin;
   logic level_mid_pin;
   logic level_empty_pin;

   modport source (
      output valid, start_press, emergency_press, count_up_press,
             count_clear_press, level_high_pin, level_mid_pin, level_empty_pin,
      input  ready
   );

   modport sink (
      input  valid, start_press, emergency_press, count_up_press,
             count_clear_press, level_high_pin, level_mid_pin, level_empty_pin,
      output ready
   );
endinterface

// ----- rtl/tbs_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_rsp_if
// Result channel: phase, actuator drive pattern and remaining batch count.
// ----------------------------------------------------------------------------
interface tbs_rsp_if;
   import tbs_pkg::*;

   logic      valid;
   logic      ready;
   phase_type phase;
   drive_type drive_pattern;
   count_type batch_count;

   modport source (
      output valid, phase, drive_pattern, batch_count,
      input  ready
   );

   modport sink (
      input  valid, phase, drive_pattern, batch_count,
      output ready
   );
endinterface

// ----- rtl/tank_batch_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_batch_sequencer
// Fill / stir / drain batch controller with pause and latched emergency.
// ----------------------------------------------------------------------------
// Each request beat is one tick of button events and level pins and yields
// exactly one response beat carrying the phase after the tick, the actuator
// drive pattern and the remaining batch count. A beat is registered on entry,
// the next phase is worked out combinationally and registered into the
// response stage, and a new beat is taken every cycle as long as the response
// side keeps up. The response register lets the next beat enter while a
// finished result still waits. Only reset leaves the emergency phase.
module tank_batch_sequencer
   import tbs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tbs_req_if.sink   req_ch,
   tbs_rsp_if.source rsp_ch
);

   // input stage
   logic in_valid_ff;
   logic start_ff, emer_ff, up_ff, clr_ff, lvl_high_ff, lvl_mid_ff, lvl_empty_ff;

   // machine state
   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;
   logic      run_en_ff, run_en_in;

   // result stage
   logic      out_valid_ff;
   phase_type out_phase_ff;
   drive_type out_drive_ff, drive_in;
   count_type out_count_ff;

   logic out_free;
   logic advance;

   count_type count_btn;
   count_type count_dec;
   logic      run_en_btn;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         start_ff     <= req_ch.start_press;
         emer_ff      <= req_ch.emergency_press;
         up_ff        <= req_ch.count_up_press;
         clr_ff       <= req_ch.count_clear_press;
         lvl_high_ff  <= req_ch.level_high_pin;
         lvl_mid_ff   <= req_ch.level_mid_pin;
         lvl_empty_ff <= req_ch.level_empty_pin;
      end
   end

   // next state
   always_comb begin
      count_btn  = clr_ff ? '0 : (up_ff ? count_ff + count_type'(1) : count_ff);
      run_en_btn = run_en_ff && !emer_ff;
      count_dec  = count_btn - count_type'(1);
      phase_in   = phase_ff;
      count_in   = count_btn;
      run_en_in  = run_en_btn;
      case (phase_ff) inside
         PH_IDLE: begin
            if (start_ff && count_btn != '0) begin
               run_en_in = 1'b1;
               phase_in  = PH_FILL;
            end
         end
         PH_FILL, PH_STIR, PH_DRAIN: begin
            if (!run_en_btn) begin
               phase_in = PH_EMERGENCY;
            end else if (start_ff) begin
               case (phase_ff)
                  PH_FILL: phase_in = PH_FILL_PAUSE;
                  PH_STIR: phase_in = PH_STIR_PAUSE;
                  default: phase_in = PH_DRAIN_PAUSE;
               endcase
            end else if (phase_ff == PH_FILL) begin
               if (lvl_high_ff) phase_in = PH_STIR;
            end else if (phase_ff == PH_STIR) begin
               if (!lvl_mid_ff) phase_in = PH_DRAIN;
            end else if (!lvl_empty_ff) begin
               // drain done: one batch used up, loop back unless none remain
               if (count_btn == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  count_in = count_dec;
                  phase_in = (count_dec == '0) ? PH_IDLE : PH_FILL;
               end
            end
         end
         PH_FILL_PAUSE, PH_STIR_PAUSE, PH_DRAIN_PAUSE: begin
            if (start_ff) begin
               case (phase_ff)
                  PH_FILL_PAUSE: phase_in = PH_FILL;
                  PH_STIR_PAUSE: phase_in = PH_STIR;
                  default:       phase_in = PH_DRAIN;
               endcase
            end
         end
         default: begin
            phase_in = PH_EMERGENCY;
         end
      endcase
   end

   // outputs
   always_comb begin
      drive_in = drive_of(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         run_en_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         run_en_ff <= run_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_phase_ff <= phase_in;
         out_drive_ff <= drive_in;
         out_count_ff <= count_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.phase         = out_phase_ff;
   assign rsp_ch.drive_pattern = out_drive_ff;
   assign rsp_ch.batch_count   = out_count_ff;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tank batch sequencer. Each tick beat is applied
// to a tick-level model of the phase machine and its batch count. The
// predicted phase, drive pattern and count are queued, and every response
// beat is compared against the oldest entry. Stimulus opens with a directed
// walk through every running phase, pause and corner case. It then runs mostly
// well-formed fill / stir / drain batches with some noise and a count wrap
// run. It ends with a latched emergency. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tbs_pkg::*;

   typedef struct packed {
      logic start;
      logic emer;
      logic up;
      logic clr;
      logic hi;
      logic mid;
      logic empty;
   } tick_type;

   typedef struct {
      phase_type phase;
      drive_type drive;
      count_type count;
   } status_type;

   class tank_state_tracker;
      phase_type  phase_q;
      count_type  count_q;
      bit         run_q;
      status_type pending_status[$];
      int         errors;

      function new();
         phase_q = PH_IDLE;
         count_q = '0;
         run_q   = 1'b0;
         errors  = 0;
      endfunction

      // advance the machine by one tick and queue the status it must report
      function void note_tick(input tick_type t);
         phase_type  nxt;
         status_type s;
         nxt = phase_q;
         if (t.clr) begin
            count_q = '0;
         end else if (t.up) begin
            count_q = count_q + 1'b1;
         end
         if (t.emer) begin
            run_q = 1'b0;
         end
         case (phase_q)
            PH_IDLE: begin
               if (t.start && count_q != '0) begin
                  run_q = 1'b1;
                  nxt   = PH_FILL;
               end
            end
            PH_FILL, PH_STIR, PH_DRAIN: begin
               if (!run_q) begin
                  nxt = PH_EMERGENCY;
               end else if (t.start) begin
                  case (phase_q)
                     PH_FILL: nxt = PH_FILL_PAUSE;
                     PH_STIR: nxt = PH_STIR_PAUSE;
                     default: nxt = PH_DRAIN_PAUSE;
                  endcase
               end else if (phase_q == PH_FILL) begin
                  if (t.hi) nxt = PH_STIR;
               end else if (phase_q == PH_STIR) begin
                  if (!t.mid) nxt = PH_DRAIN;
               end else if (!t.empty) begin
                  if (count_q == '0) begin
                     nxt = PH_IDLE;
                  end else begin
                     count_q = count_q - 1'b1;
                     nxt = (count_q == '0) ? PH_IDLE : PH_FILL;
                  end
               end
            end
            PH_FILL_PAUSE: if (t.start) nxt = PH_FILL;
            PH_STIR_PAUSE: if (t.start) nxt = PH_STIR;
            PH_DRAIN_PAUSE: if (t.start) nxt = PH_DRAIN;
            default: nxt = PH_EMERGENCY;
         endcase
         phase_q = nxt;
         s.phase = nxt;
         s.count = count_q;
         case (nxt)
            PH_FILL:      s.drive = DriveFill;
            PH_STIR:      s.drive = DriveStir;
            PH_DRAIN:     s.drive = DriveDrain;
            PH_EMERGENCY: s.drive = DriveEmergency;
            default:      s.drive = DriveIdle;
         endcase
         pending_status.push_back(s);
      endfunction

      function void check_status(input phase_type ph, input drive_type dr,
                                 input count_type cnt);
         status_type s;
         if (pending_status.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected beat: phase %0d drive 0x%02h count %0d",
                        ph, dr, cnt);
            end
            return;
         end
         s = pending_status.pop_front();
         if (ph !== s.phase || dr !== s.drive || cnt !== s.count) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch at %0t", $realtime);
               $display("  expected phase %0d drive 0x%02h count %0d",
                        s.phase, s.drive, s.count);
               $display("  actual   phase %0d drive 0x%02h count %0d",
                        ph, dr, cnt);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tbs_req_if req_ch();
   tbs_rsp_if rsp_ch();

   tank_batch_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tank_state_tracker tracker = new();
   bit                calm;
   bit                gap_mode;
   int unsigned       quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit chance(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic tick_type make_tick(input int s, e, u, c, h, m, em);
      return {s[0], e[0], u[0], c[0], h[0], m[0], em[0]};
   endfunction

   // mostly well-formed batch traffic for the current phase, some pure noise
   function automatic tick_type random_tick(input bit emer_ok);
      tick_type t;
      t = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 9) != 0) begin
         t.emer  = chance(emer_ok ? 3 : 8);
         t.clr   = chance(3);
         t.up    = chance(5);
         t.start = chance(6);
         t.hi    = chance(50);
         t.mid   = chance(50);
         t.empty = chance(50);
         case (tracker.phase_q)
            PH_IDLE: begin
               t.start = chance(30);
               t.up    = chance(40);
               t.clr   = chance(5);
            end
            PH_FILL:  t.hi    = chance(30);
            PH_STIR:  t.mid   = chance(70);
            PH_DRAIN: t.empty = chance(70);
            PH_FILL_PAUSE, PH_STIR_PAUSE, PH_DRAIN_PAUSE: t.start = chance(40);
            default: begin
               t.up    = chance(30);
               t.start = chance(20);
            end
         endcase
      end
      // emergency latches for good, so keep it out of every phase but idle
      if (!emer_ok && tracker.phase_q != PH_IDLE) t.emer = 1'b0;
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      req_ch.valid             <= 1'b1;
      req_ch.start_press       <= t.start;
      req_ch.emergency_press   <= t.emer;
      req_ch.count_up_press    <= t.up;
      req_ch.count_clear_press <= t.clr;
      req_ch.level_high_pin    <= t.hi;
      req_ch.level_mid_pin     <= t.mid;
      req_ch.level_empty_pin   <= t.empty;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.note_tick(t);
      if (!calm && gap_mode && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (tracker.pending_status.size() != 0) @(posedge clock);
   endtask

   initial begin
      calm                     = 1'b0;
      gap_mode                 = 1'b0;
      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.start_press       <= 1'b0;
      req_ch.emergency_press   <= 1'b0;
      req_ch.count_up_press    <= 1'b0;
      req_ch.count_clear_press <= 1'b0;
      req_ch.level_high_pin    <= 1'b0;
      req_ch.level_mid_pin     <= 1'b0;
      req_ch.level_empty_pin   <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));   // start with zero count is ignored
      send_tick(make_tick(0, 0, 1, 1, 1, 0, 0));   // clear beats increment
      send_tick(make_tick(0, 0, 1, 0, 0, 1, 1));
      send_tick(make_tick(0, 0, 1, 0, 0, 1, 1));
      send_tick(make_tick(1, 1, 0, 0, 0, 1, 1));   // emergency and start together in idle
      send_tick(make_tick(0, 0, 0, 0, 0, 1, 1));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));   // pause fill
      send_tick(make_tick(0, 0, 0, 0, 1, 0, 0));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));   // resume fill
      send_tick(make_tick(0, 0, 0, 0, 1, 1, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 1, 1));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));   // pause stir
      send_tick(make_tick(1, 0, 0, 0, 0, 0, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 1, 1));
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 0));   // pause drain, start beats empty pin
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 1, 0));   // count 2 -> 1, back to fill
      send_tick(make_tick(0, 0, 0, 0, 1, 1, 1));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 1));
      send_tick(make_tick(0, 0, 0, 1, 0, 1, 1));   // clear while draining
      send_tick(make_tick(0, 0, 0, 0, 0, 1, 0));   // drain ends on a zero count

      // hold off until the pipeline is empty
      req_ch.valid <= 1'b0;
      wait_drained();

      for (int i = 0; i < 1000; i++) begin
         if (i % 100 == 0) gap_mode = $urandom_range(0, 1);
         if (i == 600) begin
            // long increment run so the count wraps through zero
            repeat (260) send_tick(make_tick(0, 0, 1, 0, 0, 1, 1));
            send_tick(make_tick(0, 0, 0, 1, 0, 1, 1));
         end
         send_tick(random_tick(1'b0));
      end

      calm     = 1'b1;
      gap_mode = 1'b0;
      while (tracker.phase_q != PH_FILL_PAUSE && tracker.phase_q != PH_STIR_PAUSE &&
             tracker.phase_q != PH_DRAIN_PAUSE) begin
         if (tracker.phase_q == PH_IDLE) send_tick(make_tick(1, 0, 1, 0, 0, 1, 1));
         else send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));
      end
      send_tick(make_tick(0, 1, 0, 0, 0, 1, 1));   // emergency while paused
      send_tick(make_tick(1, 0, 0, 0, 0, 1, 1));   // resume with the flag cleared
      send_tick(make_tick(1, 0, 0, 0, 1, 0, 0));   // cleared flag beats start and pins
      send_tick(make_tick(1, 1, 1, 1, 1, 1, 1));
      repeat (200) send_tick(random_tick(1'b1));

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_status.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // response side backpressure: ready runs with stall bursts in between
   initial begin
      int unsigned run_len;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            run_len = chance(12) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            rsp_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_status(rsp_ch.phase, rsp_ch.drive_pattern, rsp_ch.batch_count);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 4000) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial quiet_cycles = 0;

endmodule
